FILE: hw/rtl/dcbm_pkg.sv
// Package for the dark channel box mean unit.
// Holds the sizing constants, the queue item type and the engine state type.
// No dependencies.
package dcbm_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MaxRadius = 15;

  // Ring buffer of dark values; it covers the reach of a window behind and
  // ahead of the result position at the largest radius and width.
  localparam int unsigned StoreAw    = 15;
  localparam int unsigned StoreDepth = 1 << StoreAw;

  localparam int unsigned RadW   = 4;
  localparam int unsigned WidthW = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned ColW   = 10;
  localparam int unsigned RowW   = 12;
  localparam int unsigned PendW  = 16;
  localparam int unsigned SumW   = 18;
  localparam int unsigned CntW   = 10;
  localparam int unsigned CfgW   = 13;

  localparam logic [1:0] CfgRadius = 2'd0;
  localparam logic [1:0] CfgWidth  = 2'd1;
  localparam logic [1:0] CfgHeight = 2'd2;

  typedef struct packed {
    logic       drain;
    logic [7:0] dark;
  } dcbm_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StReady,
    StSetup,
    StSum,
    StFlush,
    StDiv,
    StDone
  } dcbm_state_e;

endpackage

FILE: hw/rtl/dcbm_front.sv
// Front end: accepts stream transactions and forms the dark value.
// Depends on dcbm_pkg.
module dcbm_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // red, green, blue
  input  logic                s_axis_tuser,  // mode: drain step when high
  output logic                push_o,
  output dcbm_pkg::dcbm_item_t item_o,
  input  logic                full_i
);
  import dcbm_pkg::*;

  logic [7:0] red, green, blue, rg_min;

  assign red    = s_axis_tdata[7:0];
  assign green  = s_axis_tdata[15:8];
  assign blue   = s_axis_tdata[23:16];
  assign rg_min = (red < green) ? red : green;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign item_o.drain  = s_axis_tuser;
  assign item_o.dark   = (blue < rg_min) ? blue : rg_min;

endmodule

FILE: hw/rtl/dcbm_fifo.sv
// Short queue between the front end and the window engine.
// Depends on dcbm_pkg.
module dcbm_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dcbm_pkg::dcbm_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output dcbm_pkg::dcbm_item_t pop_item_o
);
  import dcbm_pkg::*;

  dcbm_item_t  mem_q [4];
  logic [1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == 3'd4);
  assign valid_o    = (cnt_q != 3'd0);
  assign pop_item_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 2'd1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 2'd1 : rptr_q;
    cnt_d  = cnt_q + {2'd0, push_i} - {2'd0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/dcbm_back.sv
// Window engine: line store, readiness check, window summation and divider.
// Depends on dcbm_pkg.
module dcbm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [12:0]          cfg_data_i,
  input  logic                 valid_i,
  input  dcbm_pkg::dcbm_item_t item_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // dark_value, window_mean
  output logic                 m_axis_tlast   // frame_last
);
  import dcbm_pkg::*;

  logic [7:0] mem_q [StoreDepth];
  logic [7:0] rdata_q;
  logic [StoreAw-1:0] rd_addr;
  logic               wr_en;

  logic [RadW-1:0]    radius_q;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [RadW-1:0]    r;
  logic [WidthW-1:0]  w;
  logic [HeightW-1:0] h;

  dcbm_state_e state_q, state_d;
  logic [StoreAw-1:0] wpos_q, wpos_d, rpos_q, rpos_d;
  logic [PendW-1:0]   pend_q, pend_d;
  logic [ColW-1:0]    ox_q, ox_d;
  logic [RowW-1:0]    oy_q, oy_d;
  logic [RadW-1:0]    above_q, above_d, left_q, left_d;
  logic [4:0]         nrows_q, nrows_d, ncols_q, ncols_d;
  logic [4:0]         cx_q, cx_d, cy_q, cy_d;
  logic [StoreAw-1:0] addr_q, addr_d, row_q, row_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [9:0]         rem_q, rem_d;
  logic [4:0]         dcnt_q, dcnt_d;
  logic               rd_sum_q, rd_sum_d, rd_dark_q, rd_dark_d;
  logic [7:0]         dark_q, dark_d;
  logic               ovld_q, ovld_d, olast_q, olast_d;
  logic [15:0]        odata_q, odata_d;

  logic [HeightW-1:0] ly, oy_ext;
  logic [WidthW-1:0]  lx, ox_ext;
  logic [RadW-1:0]    dy, dx;
  logic [14:0]        need;
  logic               ready;
  logic [14:0]        back_off;
  logic [10:0]        rem_sh;
  logic [11:0]        trial;
  logic               restart;

  // Effective register values, clamped into the supported range.
  always_comb begin
    r = (radius_q == '0) ? RadW'(1) : radius_q;
    if (width_q == '0) w = WidthW'(1);
    else if (width_q > WidthW'(MaxWidth)) w = WidthW'(MaxWidth);
    else w = width_q;
    if (height_q == '0) h = HeightW'(1);
    else if (height_q > HeightW'(MaxHeight)) h = HeightW'(MaxHeight);
    else h = height_q;
  end

  // Readiness: the newest pixel of the clipped window has been taken in.
  always_comb begin
    oy_ext = {1'b0, oy_q};
    ox_ext = {1'b0, ox_q};
    ly = (oy_ext + HeightW'(r) < h - HeightW'(1)) ? oy_ext + HeightW'(r) : h - HeightW'(1);
    lx = (ox_ext + WidthW'(r) < w - WidthW'(1)) ? ox_ext + WidthW'(r) : w - WidthW'(1);
    dy = RadW'(ly - oy_ext);
    dx = RadW'(lx - ox_ext);
    need  = 15'(dy) * 15'(w) + 15'(dx);
    ready = (pend_q != '0) && (pend_q >= {1'b0, need} + PendW'(1));
    back_off = 15'(above_q) * 15'(w) + 15'(left_q);
    rem_sh = {rem_q, sum_q[SumW-1]};
    trial  = {1'b0, rem_sh} - {2'b0, count_q};
  end

  assign restart = cfg_we_i && (cfg_idx_i == CfgRadius || cfg_idx_i == CfgWidth ||
                                cfg_idx_i == CfgHeight);
  assign pop_o   = (state_q == StIdle) && valid_i;
  assign wr_en   = pop_o && !item_i.drain;
  assign rd_addr = (state_q == StSetup) ? rpos_q : addr_q;

  always_comb begin
    state_d   = state_q;
    wpos_d    = wpos_q;
    rpos_d    = rpos_q;
    pend_d    = pend_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    above_d   = above_q;
    left_d    = left_q;
    nrows_d   = nrows_q;
    ncols_d   = ncols_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    addr_d    = addr_q;
    row_d     = row_q;
    count_d   = count_q;
    sum_d     = sum_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    dark_d    = dark_q;
    rd_sum_d  = 1'b0;
    rd_dark_d = 1'b0;
    ovld_d    = ovld_q && !m_axis_tready;
    olast_d   = olast_q;
    odata_d   = odata_q;

    if (rd_sum_q) sum_d = sum_q + SumW'(rdata_q);
    if (rd_dark_q) dark_d = rdata_q;

    case (state_q)
      StIdle: begin
        if (pop_o) begin
          if (!item_i.drain) begin
            wpos_d = wpos_q + StoreAw'(1);
            pend_d = pend_q + PendW'(1);
          end
          state_d = StReady;
        end
      end
      StReady: begin
        if (ready) begin
          above_d = (oy_q < RowW'(r)) ? RadW'(oy_q) : r;
          left_d  = (ox_q < ColW'(r)) ? RadW'(ox_q) : r;
          nrows_d = 5'(above_d) + 5'(dy) + 5'd1;
          ncols_d = 5'(left_d) + 5'(dx) + 5'd1;
          state_d = StSetup;
        end else begin
          state_d = StIdle;
        end
      end
      StSetup: begin
        addr_d    = rpos_q - back_off;
        row_d     = rpos_q - back_off;
        count_d   = CntW'(nrows_q) * CntW'(ncols_q);
        cx_d      = '0;
        cy_d      = '0;
        sum_d     = '0;
        rd_dark_d = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        rd_sum_d = 1'b1;
        if (cx_q == ncols_q - 5'd1) begin
          cx_d   = '0;
          row_d  = row_q + StoreAw'(w);
          addr_d = row_q + StoreAw'(w);
          if (cy_q == nrows_q - 5'd1) state_d = StFlush;
          else cy_d = cy_q + 5'd1;
        end else begin
          cx_d   = cx_q + 5'd1;
          addr_d = addr_q + StoreAw'(1);
        end
      end
      StFlush: begin
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        // Restoring division, one quotient bit per cycle.
        sum_d  = {sum_q[SumW-2:0], ~trial[11]};
        rem_d  = trial[11] ? rem_sh[9:0] : trial[9:0];
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'(SumW - 1)) state_d = StDone;
      end
      StDone: begin
        // Wait here while the previous result still sits in the output register.
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          odata_d = {sum_q[7:0], dark_q};
          olast_d = (oy_ext == h - HeightW'(1)) && (ox_ext == w - WidthW'(1));
          rpos_d  = rpos_q + StoreAw'(1);
          pend_d  = pend_q - PendW'(1);
          if (ox_ext + WidthW'(1) >= w) begin
            ox_d = '0;
            oy_d = (oy_ext + HeightW'(1) >= h) ? '0 : oy_q + RowW'(1);
          end else begin
            ox_d = ox_q + ColW'(1);
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (restart) begin
      wpos_d = '0;
      rpos_d = '0;
      pend_d = '0;
      ox_d   = '0;
      oy_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      radius_q  <= RadW'(7);
      width_q   <= WidthW'(640);
      height_q  <= HeightW'(480);
      wpos_q    <= '0;
      rpos_q    <= '0;
      pend_q    <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      rd_sum_q  <= 1'b0;
      rd_dark_q <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      wpos_q    <= wpos_d;
      rpos_q    <= rpos_d;
      pend_q    <= pend_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      rd_sum_q  <= rd_sum_d;
      rd_dark_q <= rd_dark_d;
      ovld_q    <= ovld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRadius: radius_q <= cfg_data_i[RadW-1:0];
          CfgWidth:  width_q  <= cfg_data_i[WidthW-1:0];
          CfgHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    above_q <= above_d;
    left_q  <= left_d;
    nrows_q <= nrows_d;
    ncols_q <= ncols_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    addr_q  <= addr_d;
    row_q   <= row_d;
    count_q <= count_d;
    sum_q   <= sum_d;
    rem_q   <= rem_d;
    dcnt_q  <= dcnt_d;
    dark_q  <= dark_d;
    olast_q <= olast_d;
    odata_q <= odata_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wpos_q] <= item_i.dark;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

FILE: hw/rtl/dark_channel_box_mean_unit.sv
// Dark channel box mean unit: clipped square-window mean of min(R, G, B).
// A pixel that completes a window passes pop, readiness, setup, one store read per pixel
// of the clipped window (at most (2r+1)^2 pixels), flush, the divider and output, and the
// output step waits while the previous result is still held in the output register.
// An item is popped only once the engine is idle again, so it takes no new item meanwhile.
// Reset clears all positions and loads radius 7, width 640, height 480; the store is kept.
module dark_channel_box_mean_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // dark_value, window_mean
  output logic        m_axis_tlast    // frame_last
);
  import dcbm_pkg::*;

  dcbm_item_t push_item, pop_item;
  logic push, full, pop, qvalid;

  dcbm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .item_o        (push_item),
    .full_i        (full)
  );

  dcbm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qvalid),
    .pop_item_o  (pop_item)
  );

  dcbm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .valid_i       (qvalid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
